### design/sha_pkg.sv
// Shared types, constants and SHA-256 round functions.
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BlkWds = 16;
  localparam int unsigned HashWds = 8;

  typedef logic [WordW-1:0] word_t;

  localparam word_t PadMarker = 32'h8000_0000;

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_s0(input word_t v);
    return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
  endfunction

  function automatic word_t big_s1(input word_t v);
    return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
  endfunction

  function automatic word_t small_s0(input word_t v);
    return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(input word_t v);
    return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/sha_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr0_i,
  input  wire logic [$clog2(Depth)-1:0] raddr1_i,
  output logic      [Width-1:0]         rdata0_o,
  output logic      [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule
`default_nettype wire

### design/sha256_stream_hash.sv
// SHA-256 stream hasher: block buffer in RAM, one round per cycle, digest beats out.
// Each input beat is written into the block RAM as it is accepted; the 16th word of a block
// starts a compression (64 rounds through a 3-stage read / schedule / round pipe, plus the
// chaining add), during which no input is accepted. After the final word the padding words
// go in one per cycle, one or two more blocks are compressed, then 8 digest beats follow;
// the next message may enter meanwhile. Reset loads the initial hash and clears counters;
// the block RAM is not cleared.
`default_nettype none
module sha256_stream_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [31:0] message_word, [34:32] valid_bytes, 0 pad
  input  wire logic        s_axis_tlast_i,  // end_of_message
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,  // [31:0] digest_word, [34:32] word_index, 0 pad
  output logic             m_axis_tlast_o   // last_word
);
  import sha_pkg::*;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [6:0] CntLast = 7'd65;

  logic [1:0]  state_q, state_d;
  logic [3:0]  fill_q, fill_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] bc_q, bc_d;
  logic        pad_q, pad_d;
  logic        marker_q, marker_d;
  logic        len_hi_q, len_hi_d;
  logic        done_q, done_d;
  logic        out_busy_q, out_busy_d;
  logic [2:0]  out_idx_q, out_idx_d;
  word_t       chain_q [HashWds];
  word_t       chain_d [HashWds];
  word_t       wk_q [HashWds];
  word_t       wk_d [HashWds];
  word_t       dig_q [HashWds];
  word_t       dig_d [HashWds];
  word_t       w_q, w_d;

  logic        in_fire, out_fire;
  logic        push_en;
  word_t       push_data;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  word_t       ram_wdata;
  logic [3:0]  ra0, ra1, rb0, rb1;
  word_t       rd_a0, rd_a1, rd_b0, rd_b1;
  logic [5:0]  rnd_w, rnd_r;
  word_t       w_sched, t1, t2;
  logic [2:0]  in_nb;
  word_t       in_word, last_word;

  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o & m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_FILL) & ~pad_q;
  assign m_axis_tvalid_o = out_busy_q;
  assign m_axis_tdata_o  = {5'd0, out_idx_q, dig_q[out_idx_q]};
  assign m_axis_tlast_o  = (out_idx_q == 3'd7);

  // read addresses for round cnt: w[t-16], w[t-15] on copy A, w[t-2], w[t-7] on copy B
  assign ra0 = cnt_q[3:0];
  assign ra1 = cnt_q[3:0] + 4'd1;
  assign rb0 = cnt_q[3:0] + 4'd14;
  assign rb1 = cnt_q[3:0] + 4'd9;

  // both copies hold the same words so four schedule taps can be read per cycle
  sha_ram #(.Width(WordW), .Depth(BlkWds)) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (rd_a0),
    .rdata1_o (rd_a1)
  );

  sha_ram #(.Width(WordW), .Depth(BlkWds)) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (rb0),
    .raddr1_i (rb1),
    .rdata0_o (rd_b0),
    .rdata1_o (rd_b1)
  );

  assign rnd_w = 6'(cnt_q - 7'd1);
  assign rnd_r = 6'(cnt_q - 7'd2);

  assign w_sched = (rnd_w < 6'd16) ? rd_a0
                 : small_s1(rd_b0) + rd_b1 + small_s0(rd_a1) + rd_a0;

  assign t1 = wk_q[7] + big_s1(wk_q[4]) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
            + round_k(rnd_r) + w_q;
  assign t2 = big_s0(wk_q[0])
            + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

  // final-word formatting: valid count above four counts as four
  assign in_word = s_axis_tdata_i[31:0];
  assign in_nb   = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];

  always_comb begin
    case (in_nb)
      3'd0:    last_word = PadMarker;
      3'd1:    last_word = {in_word[31:24], 24'h80_0000};
      3'd2:    last_word = {in_word[31:16], 16'h8000};
      3'd3:    last_word = {in_word[31:8], 8'h80};
      default: last_word = in_word;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    bc_d       = bc_q;
    pad_d      = pad_q;
    marker_d   = marker_q;
    len_hi_d   = len_hi_q;
    done_d     = done_q;
    out_busy_d = out_busy_q;
    out_idx_d  = out_idx_q;
    chain_d    = chain_q;
    wk_d       = wk_q;
    dig_d      = dig_q;
    w_d        = w_q;
    push_en    = 1'b0;
    push_data  = in_word;

    if (out_fire) begin
      out_idx_d = out_idx_q + 3'd1;
      if (out_idx_q == 3'd7) begin
        out_busy_d = 1'b0;
      end
    end

    case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          push_en = 1'b1;
          if (!s_axis_tlast_i) begin
            bc_d = bc_q + 64'd32;
          end else begin
            bc_d      = bc_q + 64'({in_nb, 3'b000});
            pad_d     = 1'b1;
            push_data = last_word;
            marker_d  = (in_nb == 3'd4);
          end
        end else if (pad_q) begin
          push_en = 1'b1;
          if (marker_q) begin
            push_data = PadMarker;
            marker_d  = 1'b0;
          end else if (fill_q == 4'd14 && !len_hi_q) begin
            push_data = bc_q[63:32];
            len_hi_d  = 1'b1;
          end else if (fill_q == 4'd15 && len_hi_q) begin
            push_data = bc_q[31:0];
            done_d    = 1'b1;
          end else begin
            push_data = '0;
          end
        end
        if (push_en) begin
          fill_d = fill_q + 4'd1;
          if (fill_q == 4'd15) begin
            state_d = ST_COMP;
            cnt_d   = '0;
            wk_d    = chain_q;
          end
        end
      end
      ST_COMP: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q >= 7'd1 && cnt_q <= 7'd64) begin
          w_d = w_sched;
        end
        if (cnt_q >= 7'd2) begin
          wk_d[7] = wk_q[6];
          wk_d[6] = wk_q[5];
          wk_d[5] = wk_q[4];
          wk_d[4] = wk_q[3] + t1;
          wk_d[3] = wk_q[2];
          wk_d[2] = wk_q[1];
          wk_d[1] = wk_q[0];
          wk_d[0] = t1 + t2;
        end
        if (cnt_q == CntLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!done_q) begin
          for (int i = 0; i < HashWds; i++) begin
            chain_d[i] = chain_q[i] + wk_q[i];
          end
          state_d = ST_FILL;
        end else if (!out_busy_q) begin
          for (int i = 0; i < HashWds; i++) begin
            dig_d[i]   = chain_q[i] + wk_q[i];
            chain_d[i] = init_hash(3'(i));
          end
          out_busy_d = 1'b1;
          out_idx_d  = '0;
          bc_d       = '0;
          pad_d      = 1'b0;
          marker_d   = 1'b0;
          len_hi_d   = 1'b0;
          done_d     = 1'b0;
          state_d    = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  // buffer fill and schedule write-back share the RAM write port
  always_comb begin
    if (state_q == ST_COMP) begin
      ram_we    = (cnt_q >= 7'd1) && (cnt_q <= 7'd64) && (rnd_w >= 6'd16);
      ram_waddr = rnd_w[3:0];
      ram_wdata = w_sched;
    end else begin
      ram_we    = push_en;
      ram_waddr = fill_q;
      ram_wdata = push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_q     <= '0;
      cnt_q      <= '0;
      bc_q       <= '0;
      pad_q      <= 1'b0;
      marker_q   <= 1'b0;
      len_hi_q   <= 1'b0;
      done_q     <= 1'b0;
      out_busy_q <= 1'b0;
      out_idx_q  <= '0;
      for (int i = 0; i < HashWds; i++) begin
        chain_q[i] <= init_hash(3'(i));
      end
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      bc_q       <= bc_d;
      pad_q      <= pad_d;
      marker_q   <= marker_d;
      len_hi_q   <= len_hi_d;
      done_q     <= done_d;
      out_busy_q <= out_busy_d;
      out_idx_q  <= out_idx_d;
      chain_q    <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    dig_q <= dig_d;
    w_q   <= w_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP) |-> (cnt_q <= CntLast))
    else $error("round counter ran past the last round");

  a_done_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && $past(state_q) != ST_DONE) |->
      ($past(state_q) == ST_COMP && $past(cnt_q) == CntLast))
    else $error("chaining add entered before all rounds finished");

  a_len_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && pad_q && !marker_q && len_hi_q && fill_q == 4'd15) |=>
      (state_q == ST_COMP && done_q))
    else $error("length word did not close the final block");

  a_dig_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_busy_q) |-> ($past(state_q) == ST_DONE && $past(done_q)))
    else $error("digest beats started without a finished message");

  a_out_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("digest beats continued past the eighth word");

endmodule
`default_nettype wire
